/* hw/rtl/asbp_pkg.sv */
// Shared constants and types for the alphabet symbol bit packer.
`timescale 1ns / 1ps

package asbp_pkg;

    // Alphabet and counter sizing
    localparam int ALPHABET_MAX = 16;
    localparam int INDEX_WIDTH  = $clog2(ALPHABET_MAX);
    localparam int COUNT_WIDTH  = 24;

    // Configuration register indexes
    localparam logic [1:0] REG_ALPHABET_LOW  = 2'd0;
    localparam logic [1:0] REG_ALPHABET_HIGH = 2'd1;
    localparam logic [1:0] REG_ALPHABET_SIZE = 2'd2;
    localparam logic [1:0] REG_SYMBOL_BITS   = 2'd3;

    // Reset values of the configuration registers
    localparam logic [4:0] ALPHABET_SIZE_RESET = 5'd4;
    localparam logic [3:0] SYMBOL_BITS_RESET   = 4'd3;

    // Widest symbol and the byte it packs into
    localparam logic [3:0] SYMBOL_BITS_MAX = 4'd8;

    // One packed output byte
    typedef struct packed {
        logic [7:0]             packed_byte;
        logic                   byte_last;
        logic                   not_found;
        logic [COUNT_WIDTH-1:0] total_bits;
    } result_t;

endpackage

/* hw/rtl/asbp_if.sv */
// Valid/ready channel interfaces for characters in and packed bytes out.
`timescale 1ns / 1ps

interface asbp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       is_last;

    modport source (output valid, output character, output is_last, input ready);
    modport sink   (input valid, input character, input is_last, output ready);
endinterface

interface asbp_out_if;
    import asbp_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [7:0]             packed_byte;
    logic                   byte_last;
    logic                   not_found;
    logic [COUNT_WIDTH-1:0] total_bits;

    modport source (output valid, output packed_byte, output byte_last,
                    output not_found, output total_bits, input ready);
    modport sink   (input valid, input packed_byte, input byte_last,
                    input not_found, input total_bits, output ready);
endinterface

/* hw/rtl/alphabet_symbol_bit_packer_core.sv */
// Alphabet symbol bit packer: character lookup, bit packing and output queue.
`timescale 1ns / 1ps

// Characters are taken into an input register, looked up against the configured
// alphabet by sixteen parallel compares, and their symbol bits are packed LSB
// first into a byte accumulator in the same cycle. Finished bytes (at most two
// per character: one full byte plus a flush on the last character) go into a
// four-entry output queue, so a new character is taken every cycle while the
// queue has room for two bytes. A character passes through the input register
// and the output queue before its first byte appears on the output. Sustained
// rate is one character per cycle as long as the sink takes bytes; a character
// that yields two bytes is absorbed by the queue. Configuration must be written
// only while the block is idle; the block itself does not enforce this.
module alphabet_symbol_bit_packer_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [63:0]       cfg_data,
    asbp_in_if.sink           sym_in,
    asbp_out_if.source        byte_out
);
    import asbp_pkg::*;

    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_WIDTH   = $clog2(QUEUE_DEPTH);

    // Configuration registers
    logic [63:0] alphabet_low_reg;
    logic [63:0] alphabet_high_reg;
    logic [4:0]  alphabet_size_reg;
    logic [3:0]  symbol_bits_reg;

    // Input register
    logic       s1_valid_reg;
    logic [7:0] s1_char_reg;
    logic       s1_last_reg;

    // Packing state
    logic [7:0]             pending_bits_reg, pending_bits_next;
    logic [2:0]             pending_count_reg, pending_count_next;
    logic [COUNT_WIDTH-1:0] bit_total_reg, bit_total_next;
    logic                   miss_seen_reg, miss_seen_next;

    // Output queue
    result_t              queue_reg [QUEUE_DEPTH];
    logic [PTR_WIDTH-1:0] wr_ptr_reg;
    logic [PTR_WIDTH-1:0] rd_ptr_reg;
    logic [PTR_WIDTH:0]   fill_reg;

    // Datapath signals
    logic [127:0]           alphabet;
    logic [INDEX_WIDTH-1:0] idx;
    logic                   miss;
    logic [3:0]             nbits;
    logic [8:0]             sym_mask;
    logic [7:0]             sym;
    logic [15:0]            acc;
    logic [3:0]             count;
    logic                   m_all;
    logic [COUNT_WIDTH:0]   total_sum;
    logic [COUNT_WIDTH-1:0] total_sat;
    logic                   has_full;
    logic                   has_flush;
    logic [7:0]             rem_byte;
    logic [3:0]             rem_count;
    logic                   rem_miss;
    result_t                res_full;
    result_t                res_flush;
    result_t                res_first;
    logic [1:0]             push_n;
    logic                   s1_advance;
    logic                   pop;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alphabet_low_reg  <= '0;
            alphabet_high_reg <= '0;
            alphabet_size_reg <= ALPHABET_SIZE_RESET;
            symbol_bits_reg   <= SYMBOL_BITS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ALPHABET_LOW:  alphabet_low_reg  <= cfg_data;
                REG_ALPHABET_HIGH: alphabet_high_reg <= cfg_data;
                REG_ALPHABET_SIZE: alphabet_size_reg <= cfg_data[4:0];
                REG_SYMBOL_BITS:   symbol_bits_reg   <= cfg_data[3:0];
                default:           alphabet_low_reg  <= alphabet_low_reg;
            endcase
        end
    end

    // Handshake: move the input register on when the queue can take two bytes
    assign s1_advance   = s1_valid_reg && (fill_reg <= (PTR_WIDTH+1)'(QUEUE_DEPTH - 2));
    assign sym_in.ready = !s1_valid_reg || s1_advance;
    assign pop          = byte_out.valid && byte_out.ready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (sym_in.ready)
        begin
            s1_valid_reg <= sym_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sym_in.valid && sym_in.ready)
        begin
            s1_char_reg <= sym_in.character;
            s1_last_reg <= sym_in.is_last;
        end
    end

    // Look up the character: lowest matching position wins
    assign alphabet = {alphabet_high_reg, alphabet_low_reg};

    always_comb
    begin
        idx  = '0;
        miss = 1'b1;
        for (int p = ALPHABET_MAX - 1; p >= 0; p--)
        begin
            if ((5'(p) < alphabet_size_reg) && (alphabet[p*8 +: 8] == s1_char_reg))
            begin
                idx  = INDEX_WIDTH'(p);
                miss = 1'b0;
            end
        end
    end

    // Append the symbol to the accumulator
    assign nbits     = (symbol_bits_reg > SYMBOL_BITS_MAX) ? SYMBOL_BITS_MAX : symbol_bits_reg;
    assign sym_mask  = (9'd1 << nbits) - 9'd1;
    assign sym       = 8'(idx) & sym_mask[7:0];
    assign acc       = {8'd0, pending_bits_reg} | ({8'd0, sym} << pending_count_reg);
    assign count     = {1'b0, pending_count_reg} + nbits;
    assign m_all     = miss_seen_reg | miss;
    assign total_sum = {1'b0, bit_total_reg} + (COUNT_WIDTH+1)'(nbits);
    assign total_sat = total_sum[COUNT_WIDTH] ? '1 : total_sum[COUNT_WIDTH-1:0];

    // Split off a full byte and decide on the flush
    always_comb
    begin
        has_full = count[3];
        if (has_full)
        begin
            rem_byte  = acc[15:8];
            rem_count = count - 4'd8;
            rem_miss  = (rem_count != 4'd0) ? miss : 1'b0;
        end
        else
        begin
            rem_byte  = acc[7:0];
            rem_count = count;
            rem_miss  = m_all;
        end
        has_flush = s1_last_reg && ((rem_count != 4'd0) || !has_full);

        res_full.packed_byte = acc[7:0];
        res_full.byte_last   = s1_last_reg && (count == 4'd8);
        res_full.not_found   = m_all;
        res_full.total_bits  = res_full.byte_last ? total_sat : '0;

        res_flush.packed_byte = rem_byte;
        res_flush.byte_last   = 1'b1;
        res_flush.not_found   = rem_miss;
        res_flush.total_bits  = total_sat;

        res_first = has_full ? res_full : res_flush;
        push_n    = s1_advance ? (2'(has_full) + 2'(has_flush)) : 2'd0;
    end

    // Next packing state: clear after the last character
    always_comb
    begin
        pending_bits_next  = pending_bits_reg;
        pending_count_next = pending_count_reg;
        bit_total_next     = bit_total_reg;
        miss_seen_next     = miss_seen_reg;
        if (s1_advance)
        begin
            if (s1_last_reg)
            begin
                pending_bits_next  = '0;
                pending_count_next = '0;
                bit_total_next     = '0;
                miss_seen_next     = 1'b0;
            end
            else
            begin
                pending_bits_next  = rem_byte;
                pending_count_next = rem_count[2:0];
                bit_total_next     = total_sat;
                miss_seen_next     = rem_miss;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_bits_reg  <= '0;
            pending_count_reg <= '0;
            bit_total_reg     <= '0;
            miss_seen_reg     <= 1'b0;
        end
        else
        begin
            pending_bits_reg  <= pending_bits_next;
            pending_count_reg <= pending_count_next;
            bit_total_reg     <= bit_total_next;
            miss_seen_reg     <= miss_seen_next;
        end
    end

    // Output queue: push up to two bytes, pop one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PTR_WIDTH'(push_n);
            rd_ptr_reg <= rd_ptr_reg + PTR_WIDTH'(pop);
            fill_reg   <= fill_reg + (PTR_WIDTH+1)'(push_n) - (PTR_WIDTH+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            queue_reg[wr_ptr_reg] <= res_first;
        end
        if (push_n == 2'd2)
        begin
            queue_reg[wr_ptr_reg + PTR_WIDTH'(1)] <= res_flush;
        end
    end

    // Drive the output channel from the queue head
    assign byte_out.valid       = (fill_reg != '0);
    assign byte_out.packed_byte = queue_reg[rd_ptr_reg].packed_byte;
    assign byte_out.byte_last   = queue_reg[rd_ptr_reg].byte_last;
    assign byte_out.not_found   = queue_reg[rd_ptr_reg].not_found;
    assign byte_out.total_bits  = queue_reg[rd_ptr_reg].total_bits;

endmodule
